### hw/rtl/pctm_pkg.sv
// pctm_pkg: shared widths, constants and types of the phase-current trimmed-mean filter
// no dependencies; imported by pctm_lane, pctm_merge and bldc_phase_current_trimmed_mean
`timescale 1ns / 1ps

package pctm_pkg;

    // field widths
    localparam int CODE_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int HALL_W     = 3;
    localparam int SECTOR_W   = 3;
    localparam int MA_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // q8 gain: rounding half and fraction bits
    localparam int FRAC_BITS  = 8;
    localparam int ROUND_HALF = 128;

    // saturation limits of the milliamp values
    localparam logic signed [MA_W-1:0] MA_MAX = 16'sh7FFF;
    localparam logic signed [MA_W-1:0] MA_MIN = 16'sh8000;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_A   = 2'd0,
        CFG_GAIN_B   = 2'd1,
        CFG_OFFSET_A = 2'd2,
        CFG_OFFSET_B = 2'd3
    } t_cfg_index;

    // reset values of the registers
    localparam logic [GAIN_W-1:0] GAIN_A_RST   = 16'd1765;
    localparam logic [GAIN_W-1:0] GAIN_B_RST   = 16'd1765;
    localparam logic [CODE_W-1:0] OFFSET_A_RST = 12'd1788;
    localparam logic [CODE_W-1:0] OFFSET_B_RST = 12'd1786;

    // lane pipeline: product, window, sum/min/max, numerator, reciprocal, mean
    localparam int LANE_STAGES = 6;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } t_lane_ctl;

endpackage

### hw/rtl/pctm_lane.sv
// pctm_lane: one phase: adc code to milliamps, sliding window, trimmed mean
// depends on pctm_pkg; instantiated twice by bldc_phase_current_trimmed_mean
`timescale 1ns / 1ps

module pctm_lane #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pctm_pkg::t_lane_ctl                 i_ctl,
    input  logic        [pctm_pkg::CODE_W-1:0]  i_code,
    input  logic        [pctm_pkg::GAIN_W-1:0]  i_gain,
    input  logic        [pctm_pkg::CODE_W-1:0]  i_offset,
    output logic signed [pctm_pkg::MA_W-1:0]    o_mean
);
    import pctm_pkg::*;

    localparam int DIV    = WINDOW_DEPTH - 2;
    localparam int DIV2   = 2 * DIV;
    localparam int PROD_W = CODE_W + 1 + GAIN_W + 1;
    localparam int SUM_W  = MA_W + $clog2(WINDOW_DEPTH);
    localparam int X_W    = SUM_W + 1;
    localparam int SHIFT  = X_W + $clog2(DIV2);
    localparam int QP_W   = X_W + SHIFT;
    // ceil(2^SHIFT / DIV2): exact floor division for every numerator below 2^X_W
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((64'd1 << SHIFT) + 64'(DIV2) - 64'd1) / 64'(DIV2));
    localparam logic signed [PROD_W-1:0] P_HI = PROD_W'(MA_MAX);
    localparam logic signed [PROD_W-1:0] P_LO = PROD_W'(MA_MIN);

    // stage 0: gain times (code minus offset), exact q8
    logic signed [CODE_W:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r_prod;

    assign diff = $signed({1'b0, i_code}) - $signed({1'b0, i_offset});
    assign prod = diff * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_prod <= prod;
        end
    end

    // stage 1: round half up, saturate, push into the window
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] scaled;
    logic signed [MA_W-1:0]   sample;
    logic signed [MA_W-1:0]   r_win [WINDOW_DEPTH];

    always_comb begin
        rounded = r_prod + PROD_W'(ROUND_HALF);
        scaled  = rounded >>> FRAC_BITS;
        if (scaled > P_HI) begin
            sample = MA_MAX;
        end else if (scaled < P_LO) begin
            sample = MA_MIN;
        end else begin
            sample = MA_W'(scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.load[1]) begin
            r_win[0] <= sample;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // stage 2: window sum, minimum and maximum
    logic signed [SUM_W-1:0] sum;
    logic signed [MA_W-1:0]  mn;
    logic signed [MA_W-1:0]  mx;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [MA_W-1:0]  r_min;
    logic signed [MA_W-1:0]  r_max;

    always_comb begin
        sum = '0;
        mn  = r_win[0];
        mx  = r_win[0];
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            sum = sum + SUM_W'(r_win[i]);
            if (r_win[i] < mn) begin
                mn = r_win[i];
            end
            if (r_win[i] > mx) begin
                mx = r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_sum <= sum;
            r_min <= mn;
            r_max <= mx;
        end
    end

    // stage 3: trimmed sum as sign and doubled magnitude plus divisor
    logic signed [SUM_W-1:0] num;
    logic        [SUM_W-1:0] mag;
    logic                    neg;
    logic        [X_W-1:0]   x;
    logic        [X_W-1:0]   r_x;
    logic                    r_neg3;

    always_comb begin
        num = r_sum - SUM_W'(r_min) - SUM_W'(r_max);
        neg = num[SUM_W-1];
        mag = neg ? SUM_W'(-num) : SUM_W'(num);
        x   = {mag, 1'b0} + X_W'(DIV);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_x    <= x;
            r_neg3 <= neg;
        end
    end

    // stage 4: divide by twice the divisor through the reciprocal
    logic [QP_W-1:0] r_qprod;
    logic            r_neg4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r_qprod <= QP_W'(r_x) * QP_W'(RECIP);
            r_neg4  <= r_neg3;
        end
    end

    // stage 5: apply the sign; magnitude never exceeds 32768
    logic [MA_W:0]          q_mag;
    logic signed [MA_W-1:0] r_mean;

    assign q_mag = r_qprod[SHIFT +: MA_W+1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r_mean <= r_neg4 ? MA_W'(~q_mag + 1'b1) : MA_W'(q_mag);
        end
    end

    assign o_mean = r_mean;

    // window shifts by one place on every pushed sample
    a_window_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load[1] |=> r_win[1] == $past(r_win[0]))
        else $error("window did not shift on push");

endmodule

### hw/rtl/pctm_merge.sv
// pctm_merge: hall sector decode, feedback selection with hold, output register
// depends on pctm_pkg; instantiated by bldc_phase_current_trimmed_mean
`timescale 1ns / 1ps

module pctm_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_stall,
    input  logic signed [pctm_pkg::MA_W-1:0]     i_fa,
    input  logic signed [pctm_pkg::MA_W-1:0]     i_fb,
    input  logic        [pctm_pkg::HALL_W-1:0]   i_hall,
    output logic                                 o_move,
    output logic                                 o_valid,
    output logic signed [pctm_pkg::MA_W-1:0]     o_filtered_a_ma,
    output logic signed [pctm_pkg::MA_W-1:0]     o_filtered_b_ma,
    output logic signed [pctm_pkg::MA_W-1:0]     o_feedback_ma,
    output logic        [pctm_pkg::SECTOR_W-1:0] o_sector
);
    import pctm_pkg::*;

    // hall patterns, h1 h2 h3
    localparam logic [HALL_W-1:0] HALL_S0 = 3'b010;
    localparam logic [HALL_W-1:0] HALL_S1 = 3'b011;
    localparam logic [HALL_W-1:0] HALL_S2 = 3'b001;
    localparam logic [HALL_W-1:0] HALL_S3 = 3'b101;
    localparam logic [HALL_W-1:0] HALL_S4 = 3'b100;
    localparam logic [HALL_W-1:0] HALL_S5 = 3'b110;

    // sector codes
    localparam logic [SECTOR_W-1:0] SECTOR_0       = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1       = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2       = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3       = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4       = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_5       = 3'd5;
    localparam logic [SECTOR_W-1:0] SECTOR_INVALID = 3'd6;

    // negate with the most negative value clamped to the positive limit
    function automatic logic signed [MA_W-1:0] neg_sat(input logic signed [MA_W-1:0] v);
        if (v == MA_MIN) begin
            return MA_MAX;
        end
        return -v;
    endfunction

    logic                   load;
    logic                   upd;
    logic [SECTOR_W-1:0]    sec;
    logic signed [MA_W-1:0] fb_new;
    logic                   r_valid;
    logic signed [MA_W-1:0] r_fa;
    logic signed [MA_W-1:0] r_fb;
    logic signed [MA_W-1:0] r_held;
    logic [SECTOR_W-1:0]    r_sector;

    // output register frees up when empty or when its beat is taken
    assign o_move = !r_valid || !i_stall;
    assign load   = i_valid && o_move;

    // sector decode and feedback choice
    always_comb begin
        upd    = 1'b1;
        sec    = SECTOR_INVALID;
        fb_new = r_held;
        unique case (i_hall)
            HALL_S0: begin
                sec    = SECTOR_0;
                fb_new = neg_sat(i_fa);
            end
            HALL_S1: begin
                sec    = SECTOR_1;
                fb_new = neg_sat(i_fa);
            end
            HALL_S2: begin
                sec    = SECTOR_2;
                fb_new = neg_sat(i_fb);
            end
            HALL_S3: begin
                sec    = SECTOR_3;
                fb_new = neg_sat(i_fb);
            end
            HALL_S4: begin
                sec    = SECTOR_4;
                fb_new = i_fa;
            end
            HALL_S5: begin
                sec    = SECTOR_5;
                fb_new = i_fb;
            end
            default: begin
                upd = 1'b0;
            end
        endcase
    end

    // output beat and held feedback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_held  <= '0;
        end else begin
            if (o_move) begin
                r_valid <= i_valid;
            end
            if (load && upd) begin
                r_held <= fb_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fa     <= i_fa;
            r_fb     <= i_fb;
            r_sector <= sec;
        end
    end

    assign o_valid         = r_valid;
    assign o_filtered_a_ma = r_fa;
    assign o_filtered_b_ma = r_fb;
    assign o_feedback_ma   = r_held;
    assign o_sector        = r_sector;

    // invalid hall keeps the previous feedback
    a_hold_on_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !upd) |=> $stable(r_held))
        else $error("feedback changed on invalid hall state");

endmodule

### hw/rtl/bldc_phase_current_trimmed_mean.sv
// bldc_phase_current_trimmed_mean: top level, configuration registers and pipeline control
// depends on pctm_pkg, pctm_lane and pctm_merge
`timescale 1ns / 1ps

// Phase-current filter for a BLDC drive. Each input beat carries one ADC code per
// phase and the hall state; each code becomes signed milliamps (q8 gain times code
// minus offset, rounded and saturated), enters a WINDOW_DEPTH-deep window per phase,
// and the window sum less its minimum and maximum, divided by WINDOW_DEPTH-2 and
// rounded half away from zero, is the filtered value. The hall state picks the
// feedback current; 000 and 111 give sector 6 and keep the last feedback. The block
// takes one beat every clock cycle while o_in_stall is low, and each result passes
// through six stages in each phase lane (multiply, window push, sum and
// extremes, trimmed numerator, reciprocal multiply, sign) and the output register.
// Stages advance independently, so bubbles close up while the output is stalled.
// Windows and held feedback start at zero after reset; write the gain and offset
// registers only while no beat is in flight.
module bldc_phase_current_trimmed_mean #(
    parameter int WINDOW_DEPTH = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic        [pctm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [pctm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [pctm_pkg::CODE_W-1:0]     i_sample_a,
    input  logic        [pctm_pkg::CODE_W-1:0]     i_sample_b,
    input  logic        [pctm_pkg::HALL_W-1:0]     i_hall_state,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pctm_pkg::MA_W-1:0]       o_filtered_a_ma,
    output logic signed [pctm_pkg::MA_W-1:0]       o_filtered_b_ma,
    output logic signed [pctm_pkg::MA_W-1:0]       o_feedback_ma,
    output logic        [pctm_pkg::SECTOR_W-1:0]   o_sector
);
    import pctm_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] r_gain_a;
    logic [GAIN_W-1:0] r_gain_b;
    logic [CODE_W-1:0] r_offset_a;
    logic [CODE_W-1:0] r_offset_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_a   <= GAIN_A_RST;
            r_gain_b   <= GAIN_B_RST;
            r_offset_a <= OFFSET_A_RST;
            r_offset_b <= OFFSET_B_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GAIN_A:   r_gain_a   <= i_cfg_data;
                CFG_GAIN_B:   r_gain_b   <= i_cfg_data;
                CFG_OFFSET_A: r_offset_a <= i_cfg_data[CODE_W-1:0];
                CFG_OFFSET_B: r_offset_b <= i_cfg_data[CODE_W-1:0];
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    logic [LANE_STAGES-1:0] r_v;
    logic [LANE_STAGES-1:0] n_v;
    logic [LANE_STAGES:0]   move;
    t_lane_ctl              ctl;
    logic                   merge_move;

    always_comb begin
        move[LANE_STAGES] = merge_move;
        for (int k = LANE_STAGES - 1; k >= 0; k--) begin
            move[k] = !r_v[k] || move[k+1];
        end
        for (int k = 0; k < LANE_STAGES; k++) begin
            if (k == 0) begin
                ctl.load[k] = move[k] && i_in_valid;
                n_v[k]      = move[k] ? i_in_valid : r_v[k];
            end else begin
                ctl.load[k] = move[k] && r_v[k-1];
                n_v[k]      = move[k] ? r_v[k-1] : r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_stall = !move[0];

    // hall state rides along with the lane stages
    logic [HALL_W-1:0] r_hall [LANE_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANE_STAGES; k++) begin
            if (ctl.load[k]) begin
                r_hall[k] <= (k == 0) ? i_hall_state : r_hall[(k == 0) ? 0 : k-1];
            end
        end
    end

    // phase lanes
    logic signed [MA_W-1:0] mean_a;
    logic signed [MA_W-1:0] mean_b;

    pctm_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_code   (i_sample_a),
        .i_gain   (r_gain_a),
        .i_offset (r_offset_a),
        .o_mean   (mean_a)
    );

    pctm_lane #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_lane_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_code   (i_sample_b),
        .i_gain   (r_gain_b),
        .i_offset (r_offset_b),
        .o_mean   (mean_b)
    );

    // sector selection and output beat
    pctm_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_v[LANE_STAGES-1]),
        .i_stall         (i_out_stall),
        .i_fa            (mean_a),
        .i_fb            (mean_b),
        .i_hall          (r_hall[LANE_STAGES-1]),
        .o_move          (merge_move),
        .o_valid         (o_out_valid),
        .o_filtered_a_ma (o_filtered_a_ma),
        .o_filtered_b_ma (o_filtered_b_ma),
        .o_feedback_ma   (o_feedback_ma),
        .o_sector        (o_sector)
    );

    // input stalls only when every stage is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_v) && o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted beat occupies the first stage
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v[0])
        else $error("accepted beat lost at first stage");

endmodule
